>>> sv/cbe_pkg.sv
// Shared opcodes, constants and the element descriptor type of the CBOR item encoder.
package cbe_pkg;

   localparam logic [3:0] OP_UINT    = 4'd0;
   localparam logic [3:0] OP_INT     = 4'd1;
   localparam logic [3:0] OP_BOOL    = 4'd2;
   localparam logic [3:0] OP_FLOAT32 = 4'd3;
   localparam logic [3:0] OP_FLOAT64 = 4'd4;
   localparam logic [3:0] OP_TEXT    = 4'd5;
   localparam logic [3:0] OP_ARRAY   = 4'd6;
   localparam logic [3:0] OP_TAG     = 4'd7;
   localparam logic [3:0] OP_OPTION  = 4'd8;
   localparam logic [3:0] OP_RAW     = 4'd9;

   localparam logic [2:0] MAJOR_UINT  = 3'd0;
   localparam logic [2:0] MAJOR_NINT  = 3'd1;
   localparam logic [2:0] MAJOR_TEXT  = 3'd3;
   localparam logic [2:0] MAJOR_ARRAY = 3'd4;

   localparam logic [4:0] AI_ONE   = 5'd24;
   localparam logic [4:0] AI_TWO   = 5'd25;
   localparam logic [4:0] AI_FOUR  = 5'd26;
   localparam logic [4:0] AI_EIGHT = 5'd27;

   localparam logic [7:0] BYTE_TAG     = 8'hd9;
   localparam logic [7:0] BYTE_NONE    = 8'hff;
   localparam logic [7:0] BYTE_ARRAY0  = 8'h80;
   localparam logic [7:0] BYTE_FALSE   = 8'hf4;
   localparam logic [7:0] BYTE_TRUE    = 8'hf5;
   localparam logic [7:0] BYTE_FLOAT32 = 8'hfa;
   localparam logic [7:0] BYTE_FLOAT64 = 8'hfb;

   localparam int unsigned MAX_BYTES = 9;
   localparam int unsigned LEN_W     = 4;

   // One encoded element: bytes left aligned, most significant first.
   typedef struct packed {
      logic [8*MAX_BYTES-1:0] bytes;
      logic [LEN_W-1:0]       len;
      logic                   err;
   } desc_type;

endpackage

>>> sv/cbe_front.sv
// Front end: classifies one input item and builds its byte descriptor.
module cbe_front (
   input  logic               req_push,
   input  logic               q_full,
   input  logic [3:0]         req_opcode,
   input  logic [63:0]        req_unsigned_value,
   input  logic signed [63:0] req_signed_value,
   input  logic               req_flag,
   input  logic [7:0]         req_tag_type,
   input  logic [7:0]         req_tag_constructor,
   input  logic [7:0]         req_tag_length,
   input  logic [7:0]         req_raw_byte,
   output logic               q_push,
   output cbe_pkg::desc_type  q_desc
);
   import cbe_pkg::*;

   logic             known_op;
   logic [63:0]      int_arg;
   logic [2:0]       int_major;
   logic [63:0]      head_arg;
   logic [2:0]       head_major;
   desc_type         head_desc;

   // Shortest head for a major type and argument.
   function automatic desc_type head_enc(input logic [2:0] major, input logic [63:0] arg);
      desc_type d;
      d.err = 1'b0;
      if (arg < 64'd24) begin
         d.bytes = {major, arg[4:0], 64'd0};
         d.len   = LEN_W'(1);
      end else if (arg <= 64'hff) begin
         d.bytes = {major, AI_ONE, arg[7:0], 56'd0};
         d.len   = LEN_W'(2);
      end else if (arg <= 64'hffff) begin
         d.bytes = {major, AI_TWO, arg[15:0], 48'd0};
         d.len   = LEN_W'(3);
      end else if (arg <= 64'hffff_ffff) begin
         d.bytes = {major, AI_FOUR, arg[31:0], 32'd0};
         d.len   = LEN_W'(5);
      end else begin
         d.bytes = {major, AI_EIGHT, arg};
         d.len   = LEN_W'(9);
      end
      return d;
   endfunction

   // A negative integer carries -1-n, which is the bitwise complement.
   always_comb begin
      if (req_signed_value[63]) begin
         int_arg   = ~$unsigned(req_signed_value);
         int_major = MAJOR_NINT;
      end else begin
         int_arg   = $unsigned(req_signed_value);
         int_major = MAJOR_UINT;
      end
   end

   always_comb begin
      case (req_opcode)
         OP_INT: begin
            head_arg   = int_arg;
            head_major = int_major;
         end
         OP_TEXT: begin
            head_arg   = req_unsigned_value;
            head_major = MAJOR_TEXT;
         end
         OP_ARRAY: begin
            head_arg   = req_unsigned_value;
            head_major = MAJOR_ARRAY;
         end
         default: begin
            head_arg   = req_unsigned_value;
            head_major = MAJOR_UINT;
         end
      endcase
      head_desc = head_enc(head_major, head_arg);
   end

   always_comb begin
      known_op     = 1'b1;
      q_desc.bytes = '0;
      q_desc.len   = LEN_W'(1);
      q_desc.err   = 1'b0;
      case (req_opcode)
         OP_UINT, OP_INT, OP_TEXT, OP_ARRAY: begin
            q_desc = head_desc;
         end
         OP_BOOL: begin
            q_desc.bytes = {(req_flag ? BYTE_TRUE : BYTE_FALSE), 64'd0};
         end
         OP_FLOAT32: begin
            q_desc.bytes = {BYTE_FLOAT32, req_unsigned_value[31:0], 32'd0};
            q_desc.len   = LEN_W'(5);
         end
         OP_FLOAT64: begin
            q_desc.bytes = {BYTE_FLOAT64, req_unsigned_value};
            q_desc.len   = LEN_W'(9);
         end
         OP_TAG: begin
            if (req_tag_length >= 8'd24) begin
               q_desc.err = 1'b1;
            end else begin
               // The length is below 24, so the array head is a single byte.
               q_desc.bytes = {BYTE_TAG, req_tag_type, req_tag_constructor,
                               BYTE_ARRAY0 | req_tag_length, 40'd0};
               q_desc.len   = LEN_W'(4);
            end
         end
         OP_OPTION: begin
            q_desc.bytes = {BYTE_TAG, BYTE_NONE, 7'd0, req_flag,
                            BYTE_ARRAY0[7:1], req_flag, 40'd0};
            q_desc.len   = LEN_W'(4);
         end
         OP_RAW: begin
            q_desc.bytes = {req_raw_byte, 64'd0};
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   // Unused opcodes are taken and dropped without producing any bytes.
   assign q_push = req_push && !q_full && known_op;

endmodule

>>> sv/cbe_queue.sv
// Short descriptor queue between the front end and the byte serializer.
module cbe_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbe_pkg::desc_type push_desc,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output cbe_pkg::desc_type head_desc
);
   import cbe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign valid     = (count_ff != '0);
   assign head_desc = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue holds more entries than its depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (!valid && push) |=> valid)
      else $error("push into an empty queue did not make an entry visible");

endmodule

>>> sv/cbe_back.sv
// Back end: shifts each descriptor out one byte per transfer.
module cbe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cbe_pkg::desc_type q_desc,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic              rsp_error
);
   import cbe_pkg::*;

   logic [8*MAX_BYTES-1:0] shift_ff, shift_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic                   err_ff, err_in;
   logic                   take;

   assign rsp_empty    = (cnt_ff == '0);
   assign rsp_last     = (cnt_ff == LEN_W'(1));
   assign rsp_out_byte = shift_ff[8*MAX_BYTES-1 -: 8];
   assign rsp_error    = err_ff;
   assign take         = rsp_pop && !rsp_empty;

   // A new descriptor loads when the register is idle or its final byte leaves.
   assign q_pop = q_valid && (rsp_empty || (take && rsp_last));

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      if (q_pop) begin
         shift_in = q_desc.bytes;
         cnt_in   = q_desc.len;
         err_in   = q_desc.err;
      end else if (take) begin
         shift_in = {shift_ff[8*MAX_BYTES-9:0], 8'd0};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      err_ff   <= err_in;
   end

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> rsp_last)
      else $error("error result is not a single last byte");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LEN_W'(MAX_BYTES))
      else $error("byte count exceeds the longest element");

   a_continue: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_last) |=> !rsp_empty)
      else $error("element ended before its last byte");

   a_gapless: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_last && q_valid) |=> !rsp_empty)
      else $error("queued element not loaded after a last byte");

endmodule

>>> sv/cbor_item_encoder_unit.sv
// Top level of the CBOR item encoder: front end, descriptor queue and serializer.
//
// Usage: the input side is a queue write port. An item is transferred when
// req_push is high and req_full is low; its opcode selects the element kind.
// The result side is a queue read port. While rsp_empty is low the next
// encoded byte is on rsp_out_byte with rsp_last marking the element's final
// byte; it is transferred when rsp_pop is high. A rejected tag gives one
// transfer with rsp_error set. Items with an unused opcode are taken and
// produce nothing.
// When the block is idle, an item passes through the descriptor queue and then
// the serializer output register before its first byte is on the result ports.
// Throughput: one byte per cycle while rsp_pop is high, with no gap between
// elements while the queue holds the next one; an item has one to nine bytes.
// The front end takes one item per cycle until the QUEUE_DEPTH descriptor
// queue fills; the serializer output register is what limits the rate.
// Reset empties the queue and the output register. When the receiver stalls,
// the current byte holds and items back up into the queue, raising req_full.
module cbor_item_encoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [3:0]         req_opcode,
   input  logic [63:0]        req_unsigned_value,
   input  logic signed [63:0] req_signed_value,
   input  logic               req_flag,
   input  logic [7:0]         req_tag_type,
   input  logic [7:0]         req_tag_constructor,
   input  logic [7:0]         req_tag_length,
   input  logic [7:0]         req_raw_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_error
);
   import cbe_pkg::*;

   logic     q_push, q_pop, q_full, q_valid;
   desc_type in_desc, head_desc;

   assign req_full = q_full;

   cbe_front u_front (
      .req_push            (req_push),
      .q_full              (q_full),
      .req_opcode          (req_opcode),
      .req_unsigned_value  (req_unsigned_value),
      .req_signed_value    (req_signed_value),
      .req_flag            (req_flag),
      .req_tag_type        (req_tag_type),
      .req_tag_constructor (req_tag_constructor),
      .req_tag_length      (req_tag_length),
      .req_raw_byte        (req_raw_byte),
      .q_push              (q_push),
      .q_desc              (in_desc)
   );

   cbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (in_desc),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head_desc (head_desc)
   );

   cbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_desc       (head_desc),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule
